### rtl/mhc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the hill-climbing duty tracker.
// Used by mhc_divider and mppt_hill_climb_duty; depends on nothing else.
package mhc_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_TRACK_MODE    = 3'd0;
   localparam logic [2:0] CSR_VARIABLE_STEP = 3'd1;
   localparam logic [2:0] CSR_DUTY_FLOOR    = 3'd2;
   localparam logic [2:0] CSR_DUTY_CEILING  = 3'd3;
   localparam logic [2:0] CSR_PO_FIXED_STEP = 3'd4;
   localparam logic [2:0] CSR_IC_FIXED_STEP = 3'd5;
   localparam logic [2:0] CSR_PO_GAIN       = 3'd6;
   localparam logic [2:0] CSR_IC_GAIN       = 3'd7;

   // Register reset values
   localparam logic [15:0] DUTY_FLOOR_RST    = 16'd6554;
   localparam logic [15:0] DUTY_CEILING_RST  = 16'd62259;
   localparam logic [15:0] PO_FIXED_STEP_RST = 16'd2294;
   localparam logic [15:0] IC_FIXED_STEP_RST = 16'd1638;
   localparam logic [19:0] PO_GAIN_RST       = 20'd85899;
   localparam logic [19:0] IC_GAIN_RST       = 20'd33554;
   localparam logic [15:0] DUTY_START        = 16'd32768;

   // Quotient bits produced by the serial divider
   localparam int DIV_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CROSS_A,
      ST_CROSS_B,
      ST_GAIN,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic done;
      logic overflow;
   } div_status_type;

endpackage

### rtl/mhc_divider.sv
`timescale 1ns / 1ps
// Serial restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// Depends on mhc_pkg (DIV_BITS, div_status_type).
module mhc_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            dividend,
   input  logic [15:0]            divisor,
   output logic [15:0]            quotient,
   output mhc_pkg::div_status_type status
);

   localparam int CNT_W = $clog2(mhc_pkg::DIV_BITS);

   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      low_ff, low_in;
   logic [15:0]      dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;

   logic [16:0] shifted;
   logic [17:0] trial;
   logic        qbit;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, low_ff[15]};
      trial   = {1'b0, shifted} - {2'b0, dsr_ff};
      qbit    = ~trial[17];
   end

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in  = ovf_ff;
      if (start) begin
         // quotient does not fit in 16 bits when the top half is not below the divisor
         rem_in  = dividend[31:16];
         low_in  = dividend[15:0];
         dsr_in  = divisor;
         ovf_in  = (dividend[31:16] >= divisor);
         cnt_in  = CNT_W'(mhc_pkg::DIV_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? trial[15:0] : shifted[15:0];
         low_in = {low_ff[14:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   assign quotient        = low_ff;
   assign status.done     = done_ff;
   assign status.overflow = ovf_ff;

endmodule

### rtl/mppt_hill_climb_duty.sv
`timescale 1ns / 1ps
// Maximum power point tracker: one panel sample in, one converter duty (Q0.16) out.
// Depends on mhc_pkg and mhc_divider.

// Each sample passes through the sequencer before the next sample can be taken:
// a single 21x21 signed multiplier is used three times in a row (the two
// incremental-conductance cross products, then gain times |dP|), then the step and
// duty are resolved. In incremental conductance mode with variable step and nonzero
// dV, the serial divider computes the step before the duty is resolved.
// req_tready is high only while the tracker is idle; a finished result sits in
// the output register until taken, and the next sample may be accepted meanwhile.
module mppt_hill_climb_duty (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // panel_voltage[15:0], panel_current[31:16], panel_power[51:32]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // duty_out[15:0], step_used[31:16], limit_hit[32]
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   // Configuration registers
   logic        mode_ff, varstep_ff;
   logic [15:0] floor_ff, ceil_ff, po_step_ff, ic_step_ff;
   logic [19:0] po_gain_ff, ic_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         varstep_ff <= 1'b0;
         floor_ff   <= mhc_pkg::DUTY_FLOOR_RST;
         ceil_ff    <= mhc_pkg::DUTY_CEILING_RST;
         po_step_ff <= mhc_pkg::PO_FIXED_STEP_RST;
         ic_step_ff <= mhc_pkg::IC_FIXED_STEP_RST;
         po_gain_ff <= mhc_pkg::PO_GAIN_RST;
         ic_gain_ff <= mhc_pkg::IC_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            mhc_pkg::CSR_TRACK_MODE:    mode_ff    <= csr_wdata[0];
            mhc_pkg::CSR_VARIABLE_STEP: varstep_ff <= csr_wdata[0];
            mhc_pkg::CSR_DUTY_FLOOR:    floor_ff   <= csr_wdata[15:0];
            mhc_pkg::CSR_DUTY_CEILING:  ceil_ff    <= csr_wdata[15:0];
            mhc_pkg::CSR_PO_FIXED_STEP: po_step_ff <= csr_wdata[15:0];
            mhc_pkg::CSR_IC_FIXED_STEP: ic_step_ff <= csr_wdata[15:0];
            mhc_pkg::CSR_PO_GAIN:       po_gain_ff <= csr_wdata;
            mhc_pkg::CSR_IC_GAIN:       ic_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers
   mhc_pkg::state_type state_ff, state_in;

   logic [15:0]        volt_ff, volt_in, curr_ff, curr_in;
   logic signed [16:0] dv_ff, dv_in, di_ff, di_in;
   logic signed [20:0] dp_ff, dp_in;
   logic signed [41:0] prod_ff, prod_in;
   logic signed [33:0] acc_ff, acc_in;
   logic               s_neg_ff, s_neg_in, s_zero_ff, s_zero_in;
   logic [15:0]        step_ff, step_in;

   logic [15:0]        last_duty_ff, last_duty_in, last_volt_ff, last_volt_in;
   logic [15:0]        last_curr_ff, last_curr_in;
   logic [19:0]        last_pow_ff, last_pow_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_duty_ff, rsp_duty_in, rsp_step_ff, rsp_step_in;
   logic               rsp_hit_ff, rsp_hit_in;

   // Shared multiplier and helpers
   logic signed [20:0] mul_a, mul_b;
   logic signed [41:0] mul_p;
   logic signed [20:0] dp_neg;
   logic signed [16:0] dv_neg;
   logic [19:0]        dp_mag;
   logic [15:0]        dv_mag;
   logic signed [33:0] s_sum;
   logic [15:0]        fixed_step;
   logic [23:0]        po_g;
   logic               div_start;
   logic [15:0]        div_quo;
   mhc_pkg::div_status_type div_stat;
   logic               dir_add, dir_sub;
   logic signed [17:0] raw_duty;
   logic               hit;
   logic               req_xfer;

   assign req_tready = (state_ff == mhc_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      dp_neg     = -dp_ff;
      dv_neg     = -dv_ff;
      dp_mag     = dp_ff[20] ? dp_neg[19:0] : dp_ff[19:0];
      dv_mag     = dv_ff[16] ? dv_neg[15:0] : dv_ff[15:0];
      s_sum      = acc_ff + prod_ff[33:0];
      fixed_step = mode_ff ? ic_step_ff : po_step_ff;
      po_g       = prod_ff[39:16];
   end

   // Multiplier operand select per sequencer step
   always_comb begin
      unique case (state_ff)
         mhc_pkg::ST_CROSS_A: begin
            mul_a = 21'(di_ff);
            mul_b = {5'b0, volt_ff};
         end
         mhc_pkg::ST_CROSS_B: begin
            mul_a = {5'b0, curr_ff};
            mul_b = 21'(dv_ff);
         end
         mhc_pkg::ST_GAIN: begin
            mul_a = {1'b0, (mode_ff ? ic_gain_ff : po_gain_ff)};
            mul_b = {1'b0, dp_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = 42'(mul_a) * 42'(mul_b);
   end

   assign div_start = (state_ff == mhc_pkg::ST_SCALE) && mode_ff && varstep_ff
                      && (dv_ff != '0);

   mhc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[39:8]),
      .divisor  (dv_mag),
      .quotient (div_quo),
      .status   (div_stat)
   );

   // Direction and limit check for the final step
   always_comb begin
      dir_add = 1'b0;
      dir_sub = 1'b0;
      if (!mode_ff) begin
         dir_add = dp_ff[20] ^ dv_ff[16];
         dir_sub = ~dir_add;
      end else if (volt_ff == '0) begin
         // no voltage: hold
      end else if (dv_ff == '0) begin
         dir_add = !di_ff[16] && (di_ff != '0);
         dir_sub = di_ff[16];
      end else if (!s_zero_ff) begin
         dir_add = (s_neg_ff != dv_ff[16]);
         dir_sub = (s_neg_ff == dv_ff[16]);
      end
      priority if (dir_add) raw_duty = $signed({2'b0, last_duty_ff}) + $signed({2'b0, step_ff});
      else if (dir_sub)     raw_duty = $signed({2'b0, last_duty_ff}) - $signed({2'b0, step_ff});
      else                  raw_duty = $signed({2'b0, last_duty_ff});
      hit = (raw_duty >= $signed({2'b0, ceil_ff})) || (raw_duty <= $signed({2'b0, floor_ff}));
   end

   // Next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      volt_in      = volt_ff;
      curr_in      = curr_ff;
      dv_in        = dv_ff;
      di_in        = di_ff;
      dp_in        = dp_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      s_neg_in     = s_neg_ff;
      s_zero_in    = s_zero_ff;
      step_in      = step_ff;
      last_duty_in = last_duty_ff;
      last_volt_in = last_volt_ff;
      last_curr_in = last_curr_ff;
      last_pow_in  = last_pow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_hit_in   = rsp_hit_ff;

      // drop the result once transferred
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         mhc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               volt_in = req_tdata[15:0];
               curr_in = req_tdata[31:16];
               dv_in   = $signed({1'b0, req_tdata[15:0]}) - $signed({1'b0, last_volt_ff});
               di_in   = $signed({1'b0, req_tdata[31:16]}) - $signed({1'b0, last_curr_ff});
               dp_in   = $signed({1'b0, req_tdata[51:32]}) - $signed({1'b0, last_pow_ff});
               last_pow_in = req_tdata[51:32];
               state_in = mhc_pkg::ST_CROSS_A;
            end
         end
         mhc_pkg::ST_CROSS_A: begin
            prod_in  = mul_p;
            state_in = mhc_pkg::ST_CROSS_B;
         end
         mhc_pkg::ST_CROSS_B: begin
            acc_in   = prod_ff[33:0];
            prod_in  = mul_p;
            state_in = mhc_pkg::ST_GAIN;
         end
         mhc_pkg::ST_GAIN: begin
            s_neg_in  = s_sum[33];
            s_zero_in = (s_sum == '0);
            prod_in   = mul_p;
            state_in  = mhc_pkg::ST_SCALE;
         end
         mhc_pkg::ST_SCALE: begin
            // fixed step unless a smaller slope-scaled step applies
            step_in  = fixed_step;
            state_in = mhc_pkg::ST_FINISH;
            if (div_start) begin
               state_in = mhc_pkg::ST_DIVIDE;
            end else if (varstep_ff && !mode_ff && (po_g < {8'b0, fixed_step})) begin
               step_in = po_g[15:0];
            end
         end
         mhc_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               step_in = (div_stat.overflow || (div_quo >= fixed_step)) ? fixed_step
                                                                         : div_quo;
               state_in = mhc_pkg::ST_FINISH;
            end
         end
         mhc_pkg::ST_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = hit ? last_duty_ff : raw_duty[15:0];
               rsp_step_in  = step_ff;
               rsp_hit_in   = hit;
               last_duty_in = hit ? last_duty_ff : raw_duty[15:0];
               last_volt_in = volt_ff;
               if (mode_ff) last_curr_in = curr_ff;
               state_in = mhc_pkg::ST_IDLE;
            end
         end
         default: state_in = mhc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_duty_ff <= mhc_pkg::DUTY_START;
         last_volt_ff <= '0;
         last_curr_ff <= '0;
         last_pow_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_duty_ff <= last_duty_in;
         last_volt_ff <= last_volt_in;
         last_curr_ff <= last_curr_in;
         last_pow_ff  <= last_pow_in;
      end
      volt_ff     <= volt_in;
      curr_ff     <= curr_in;
      dv_ff       <= dv_in;
      di_ff       <= di_in;
      dp_ff       <= dp_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      s_neg_ff    <= s_neg_in;
      s_zero_ff   <= s_zero_in;
      step_ff     <= step_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_step_ff <= rsp_step_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_hit_ff, rsp_step_ff, rsp_duty_ff};

endmodule
